/* src/velocity_command_safety_gate_top_defines.svh */
// Assertion macros for the velocity command safety gate.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef VELOCITY_COMMAND_SAFETY_GATE_TOP_DEFINES_SVH
`define VELOCITY_COMMAND_SAFETY_GATE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define VCSG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vcsg assertion failed");
`define VCSG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vcsg assertion failed");
`else
`define VCSG_ASSERT_IMP(label, ante, cons)
`define VCSG_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* src/vcsg_pkg.sv */
// Shared types, codes and helper functions of the velocity command safety gate.
// Depends on nothing; used by every module of the block.
package vcsg_pkg;

  // Event kinds.
  localparam logic [2:0] KIND_CMD      = 3'd0;
  localparam logic [2:0] KIND_ODOM     = 3'd1;
  localparam logic [2:0] KIND_CONF     = 3'd2;
  localparam logic [2:0] KIND_TICK     = 3'd3;
  localparam logic [2:0] KIND_SHUTDOWN = 3'd4;

  // Request kinds.
  localparam logic REQ_MOVE = 1'b0;
  localparam logic REQ_STOP = 1'b1;

  // Stop reasons.
  localparam logic [2:0] REASON_NONE     = 3'd0;
  localparam logic [2:0] REASON_ODOM     = 3'd1;
  localparam logic [2:0] REASON_LOC      = 3'd2;
  localparam logic [2:0] REASON_CMD      = 3'd3;
  localparam logic [2:0] REASON_SHUTDOWN = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_MAX_VX       = 3'd0;
  localparam logic [2:0] REG_MAX_VY       = 3'd1;
  localparam logic [2:0] REG_MAX_YAW_RATE = 3'd2;
  localparam logic [2:0] REG_CMD_TIMEOUT  = 3'd3;
  localparam logic [2:0] REG_ODOM_TIMEOUT = 3'd4;
  localparam logic [2:0] REG_LOC_TIMEOUT  = 3'd5;
  localparam logic [2:0] REG_MIN_CONF     = 3'd6;
  localparam logic [2:0] REG_REQUIRE_LOC  = 3'd7;

  // Register reset values.
  localparam logic [14:0] MAX_VX_RST       = 15'd750;
  localparam logic [14:0] MAX_VY_RST       = 15'd350;
  localparam logic [14:0] MAX_YAW_RATE_RST = 15'd1000;
  localparam logic [15:0] CMD_TIMEOUT_RST  = 16'd300;
  localparam logic [15:0] ODOM_TIMEOUT_RST = 16'd500;
  localparam logic [15:0] LOC_TIMEOUT_RST  = 16'd5000;
  localparam logic [15:0] MIN_CONF_RST     = 16'd45875;

  // Defaults of the top level parameters.
  localparam int MAX_ABS_POSITION_MM_DEF = 100000;
  localparam int MAX_ABS_Z_MM_DEF        = 5000;
  localparam int MAX_JUMP_MM_DEF         = 2000;
  localparam int JUMP_WINDOW_MS_DEF      = 1000;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        time_ms;
    logic signed [23:0] axis_x;
    logic signed [23:0] axis_y;
    logic signed [23:0] axis_z;
    logic [15:0]        confidence;
    logic               not_finite;
  } item_t;

  typedef struct packed {
    logic               request_kind;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vyaw;
    logic [2:0]         stop_reason;
  } res_t;

  typedef struct packed {
    logic [14:0] max_vx;
    logic [14:0] max_vy;
    logic [14:0] max_yaw_rate;
    logic [15:0] cmd_timeout_ms;
    logic [15:0] odom_timeout_ms;
    logic [15:0] loc_timeout_ms;
    logic [15:0] min_confidence;
    logic        loc_required;
  } cfg_t;

  // Last good odometry position and the time of the last sample.
  typedef struct packed {
    logic               good_seen;
    logic signed [23:0] good_x;
    logic signed [23:0] good_y;
    logic signed [23:0] good_z;
    logic [31:0]        odom_time;
  } odom_ref_t;

  // An age with the top bit set is a negative age and is never stale.
  function automatic logic is_stale(input logic [31:0] now, input logic [31:0] then,
                                    input logic [15:0] limit);
    logic [31:0] age;
    age = now - then;
    return !age[31] && (age > {16'd0, limit});
  endfunction

  function automatic logic signed [15:0] clamp_vel(input logic signed [23:0] v,
                                                   input logic [14:0] lim);
    logic signed [24:0] v_e;
    logic signed [24:0] hi;
    logic signed [24:0] lo;
    logic signed [24:0] r;
    v_e = {v[23], v};
    hi  = {10'd0, lim};
    lo  = -hi;
    if (v_e > hi) begin
      r = hi;
    end else if (v_e < lo) begin
      r = lo;
    end else begin
      r = v_e;
    end
    return r[15:0];
  endfunction

  function automatic logic [23:0] abs24(input logic signed [23:0] v);
    logic [23:0] r;
    r = v[23] ? 24'(-v) : 24'(v);
    return r;
  endfunction

endpackage

/* src/velocity_command_safety_gate_top.sv */
// Flow: a word accepted into the input register is evaluated there, and its result,
// if any, is written to the result register when the word moves on past out_stall.
// Throughput: one word per cycle unless out_stall backs up; state updates once per word.
// Reset: rst_n is synchronous, active low; it restores register defaults, empties
// both registers and arms the gate with no command and the stop already reported.
// Depends on vcsg_pkg, vcsg_cfg_regs, vcsg_gate_core and the defines header.
`include "velocity_command_safety_gate_top_defines.svh"
module velocity_command_safety_gate_top #(
  parameter int MAX_ABS_POSITION_MM = vcsg_pkg::MAX_ABS_POSITION_MM_DEF,
  parameter int MAX_ABS_Z_MM        = vcsg_pkg::MAX_ABS_Z_MM_DEF,
  parameter int MAX_JUMP_MM         = vcsg_pkg::MAX_JUMP_MM_DEF,
  parameter int JUMP_WINDOW_MS      = vcsg_pkg::JUMP_WINDOW_MS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [31:0]        in_time_ms,
  input  logic signed [23:0] in_axis_x,
  input  logic signed [23:0] in_axis_y,
  input  logic signed [23:0] in_axis_z,
  input  logic [15:0]        in_confidence,
  input  logic               in_not_finite,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_request_kind,
  output logic signed [15:0] out_vx,
  output logic signed [15:0] out_vy,
  output logic signed [15:0] out_vyaw,
  output logic [2:0]         out_stop_reason,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic            in_vld_r;
  vcsg_pkg::item_t item_r;
  logic            out_vld_r;
  vcsg_pkg::res_t  res_r;
  logic            advance;
  logic            res_valid;
  vcsg_pkg::res_t  res;
  vcsg_pkg::cfg_t  cfg;

  assign cfg_ready = 1'b1;

  vcsg_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held word moves on when the result register is empty or being drained.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.kind       <= in_kind;
      item_r.time_ms    <= in_time_ms;
      item_r.axis_x     <= in_axis_x;
      item_r.axis_y     <= in_axis_y;
      item_r.axis_z     <= in_axis_z;
      item_r.confidence <= in_confidence;
      item_r.not_finite <= in_not_finite;
    end
  end

  vcsg_gate_core #(
    .MAX_ABS_POSITION_MM (MAX_ABS_POSITION_MM),
    .MAX_ABS_Z_MM        (MAX_ABS_Z_MM),
    .MAX_JUMP_MM         (MAX_JUMP_MM),
    .JUMP_WINDOW_MS      (JUMP_WINDOW_MS)
  ) u_gate_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (advance),
    .item      (item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= res_valid;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_request_kind = res_r.request_kind;
  assign out_vx           = res_r.vx;
  assign out_vy           = res_r.vy;
  assign out_vyaw         = res_r.vyaw;
  assign out_stop_reason  = res_r.stop_reason;

  `VCSG_ASSERT_IMP(a_stop_is_zero, out_vld_r && (res_r.request_kind == vcsg_pkg::REQ_STOP), (res_r.vx == 16'sd0) && (res_r.vy == 16'sd0) && (res_r.vyaw == 16'sd0) && (res_r.stop_reason != vcsg_pkg::REASON_NONE))
  `VCSG_ASSERT_IMP(a_move_no_reason, out_vld_r && (res_r.request_kind == vcsg_pkg::REQ_MOVE), res_r.stop_reason == vcsg_pkg::REASON_NONE)
  `VCSG_ASSERT_NXT(a_shutdown_stops, advance && (item_r.kind == vcsg_pkg::KIND_SHUTDOWN), out_vld_r && (res_r.request_kind == vcsg_pkg::REQ_STOP) && (res_r.stop_reason == vcsg_pkg::REASON_SHUTDOWN))

endmodule

/* src/vcsg_cfg_regs.sv */
// Configuration register file of the velocity command safety gate.
// Depends on vcsg_pkg for the register indexes, reset values and cfg_t.
module vcsg_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [15:0]        wr_data,
  output vcsg_pkg::cfg_t     cfg
);

  vcsg_pkg::cfg_t cfg_r;
  vcsg_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        vcsg_pkg::REG_MAX_VX:       cfg_nxt.max_vx = wr_data[14:0];
        vcsg_pkg::REG_MAX_VY:       cfg_nxt.max_vy = wr_data[14:0];
        vcsg_pkg::REG_MAX_YAW_RATE: cfg_nxt.max_yaw_rate = wr_data[14:0];
        vcsg_pkg::REG_CMD_TIMEOUT:  cfg_nxt.cmd_timeout_ms = wr_data;
        vcsg_pkg::REG_ODOM_TIMEOUT: cfg_nxt.odom_timeout_ms = wr_data;
        vcsg_pkg::REG_LOC_TIMEOUT:  cfg_nxt.loc_timeout_ms = wr_data;
        vcsg_pkg::REG_MIN_CONF:     cfg_nxt.min_confidence = wr_data;
        vcsg_pkg::REG_REQUIRE_LOC:  cfg_nxt.loc_required = wr_data[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_vx          <= vcsg_pkg::MAX_VX_RST;
      cfg_r.max_vy          <= vcsg_pkg::MAX_VY_RST;
      cfg_r.max_yaw_rate    <= vcsg_pkg::MAX_YAW_RATE_RST;
      cfg_r.cmd_timeout_ms  <= vcsg_pkg::CMD_TIMEOUT_RST;
      cfg_r.odom_timeout_ms <= vcsg_pkg::ODOM_TIMEOUT_RST;
      cfg_r.loc_timeout_ms  <= vcsg_pkg::LOC_TIMEOUT_RST;
      cfg_r.min_confidence  <= vcsg_pkg::MIN_CONF_RST;
      cfg_r.loc_required    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/vcsg_odom_check.sv */
// Odometry sample check: finiteness, position bounds and the jump test.
// Depends on vcsg_pkg for item_t, odom_ref_t and abs24.
module vcsg_odom_check #(
  parameter int MAX_ABS_POSITION_MM = vcsg_pkg::MAX_ABS_POSITION_MM_DEF,
  parameter int MAX_ABS_Z_MM        = vcsg_pkg::MAX_ABS_Z_MM_DEF,
  parameter int MAX_JUMP_MM         = vcsg_pkg::MAX_JUMP_MM_DEF,
  parameter int JUMP_WINDOW_MS      = vcsg_pkg::JUMP_WINDOW_MS_DEF
) (
  input  vcsg_pkg::item_t     item,
  input  vcsg_pkg::odom_ref_t ref_st,
  output logic                sample_ok
);

  localparam int JW = $clog2(MAX_JUMP_MM + 1);
  localparam int SW = 2 * JW + 2;
  localparam logic [23:0]   POS_LIM  = 24'(MAX_ABS_POSITION_MM);
  localparam logic [23:0]   Z_LIM    = 24'(MAX_ABS_Z_MM);
  localparam logic [24:0]   JUMP_LIM = 25'(MAX_JUMP_MM);
  localparam logic [SW-1:0] JUMP_SQ  = SW'(longint'(MAX_JUMP_MM) * longint'(MAX_JUMP_MM));
  localparam logic [31:0]   WIN      = 32'(JUMP_WINDOW_MS);

  logic               bounds_ok;
  logic signed [24:0] dx, dy, dz;
  logic [24:0]        adx, ady, adz;
  logic [2*JW-1:0]    sqx, sqy, sqz;
  logic [SW-1:0]      sq_sum;
  logic               far_axis;
  logic               jump;
  logic [31:0]        age;
  logic               in_window;

  assign bounds_ok = !item.not_finite
                     && (vcsg_pkg::abs24(item.axis_x) <= POS_LIM)
                     && (vcsg_pkg::abs24(item.axis_y) <= POS_LIM)
                     && (vcsg_pkg::abs24(item.axis_z) <= Z_LIM);

  assign dx = {item.axis_x[23], item.axis_x} - {ref_st.good_x[23], ref_st.good_x};
  assign dy = {item.axis_y[23], item.axis_y} - {ref_st.good_y[23], ref_st.good_y};
  assign dz = {item.axis_z[23], item.axis_z} - {ref_st.good_z[23], ref_st.good_z};

  assign adx = dx[24] ? 25'(-dx) : 25'(dx);
  assign ady = dy[24] ? 25'(-dy) : 25'(dy);
  assign adz = dz[24] ? 25'(-dz) : 25'(dz);

  // Any single axis beyond the limit already puts the squared distance over it,
  // so the squares only need the low bits of each difference.
  assign far_axis = (adx > JUMP_LIM) || (ady > JUMP_LIM) || (adz > JUMP_LIM);

  assign sqx = adx[JW-1:0] * adx[JW-1:0];
  assign sqy = ady[JW-1:0] * ady[JW-1:0];
  assign sqz = adz[JW-1:0] * adz[JW-1:0];
  assign sq_sum = SW'(sqx) + SW'(sqy) + SW'(sqz);

  assign jump = far_axis || (sq_sum > JUMP_SQ);

  assign age       = item.time_ms - ref_st.odom_time;
  assign in_window = (age != 32'd0) && (age < WIN);

  assign sample_ok = bounds_ok && !(ref_st.good_seen && in_window && jump);

endmodule

/* src/vcsg_gate_core.sv */
// Gate state and per-word decision: command latch, odometry and localization
// bookkeeping, tick evaluation. Depends on vcsg_pkg and vcsg_odom_check.
module vcsg_gate_core #(
  parameter int MAX_ABS_POSITION_MM = vcsg_pkg::MAX_ABS_POSITION_MM_DEF,
  parameter int MAX_ABS_Z_MM        = vcsg_pkg::MAX_ABS_Z_MM_DEF,
  parameter int MAX_JUMP_MM         = vcsg_pkg::MAX_JUMP_MM_DEF,
  parameter int JUMP_WINDOW_MS      = vcsg_pkg::JUMP_WINDOW_MS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  vcsg_pkg::item_t item,
  input  vcsg_pkg::cfg_t  cfg,
  output logic            res_valid,
  output vcsg_pkg::res_t  res
);

  logic signed [15:0]  vx_r, vy_r, vyaw_r;
  logic signed [15:0]  vx_nxt, vy_nxt, vyaw_nxt;
  logic [31:0]         cmd_time_r, cmd_time_nxt;
  logic                have_cmd_r, have_cmd_nxt;
  logic                stop_sent_r, stop_sent_nxt;
  logic                odom_seen_r, odom_seen_nxt;
  logic                odom_ok_r, odom_ok_nxt;
  vcsg_pkg::odom_ref_t odom_ref_r, odom_ref_nxt;
  logic                loc_seen_r, loc_seen_nxt;
  logic                loc_ok_r, loc_ok_nxt;
  logic [31:0]         loc_time_r, loc_time_nxt;

  logic                sample_ok;
  logic                odom_bad, loc_bad, cmd_stale;
  logic [2:0]          reason;

  vcsg_odom_check #(
    .MAX_ABS_POSITION_MM (MAX_ABS_POSITION_MM),
    .MAX_ABS_Z_MM        (MAX_ABS_Z_MM),
    .MAX_JUMP_MM         (MAX_JUMP_MM),
    .JUMP_WINDOW_MS      (JUMP_WINDOW_MS)
  ) u_odom_check (
    .item      (item),
    .ref_st    (odom_ref_r),
    .sample_ok (sample_ok)
  );

  assign odom_bad = !odom_seen_r || !odom_ok_r
                    || vcsg_pkg::is_stale(item.time_ms, odom_ref_r.odom_time,
                                          cfg.odom_timeout_ms);
  assign loc_bad  = cfg.loc_required
                    && (!loc_seen_r || !loc_ok_r
                        || vcsg_pkg::is_stale(item.time_ms, loc_time_r, cfg.loc_timeout_ms));
  assign cmd_stale = vcsg_pkg::is_stale(item.time_ms, cmd_time_r, cfg.cmd_timeout_ms);

  always_comb begin
    if (odom_bad) begin
      reason = vcsg_pkg::REASON_ODOM;
    end else if (loc_bad) begin
      reason = vcsg_pkg::REASON_LOC;
    end else if (cmd_stale) begin
      reason = vcsg_pkg::REASON_CMD;
    end else begin
      reason = vcsg_pkg::REASON_NONE;
    end
  end

  always_comb begin
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    vyaw_nxt      = vyaw_r;
    cmd_time_nxt  = cmd_time_r;
    have_cmd_nxt  = have_cmd_r;
    stop_sent_nxt = stop_sent_r;
    odom_seen_nxt = odom_seen_r;
    odom_ok_nxt   = odom_ok_r;
    odom_ref_nxt  = odom_ref_r;
    loc_seen_nxt  = loc_seen_r;
    loc_ok_nxt    = loc_ok_r;
    loc_time_nxt  = loc_time_r;
    res_valid     = 1'b0;
    res.request_kind = vcsg_pkg::REQ_STOP;
    res.vx           = '0;
    res.vy           = '0;
    res.vyaw         = '0;
    res.stop_reason  = reason;

    case (item.kind)
      vcsg_pkg::KIND_CMD: begin
        // A non-finite command is dropped without touching the latch.
        if (!item.not_finite) begin
          vx_nxt       = vcsg_pkg::clamp_vel(item.axis_x, cfg.max_vx);
          vy_nxt       = vcsg_pkg::clamp_vel(item.axis_y, cfg.max_vy);
          vyaw_nxt     = vcsg_pkg::clamp_vel(item.axis_z, cfg.max_yaw_rate);
          cmd_time_nxt = item.time_ms;
          have_cmd_nxt = 1'b1;
        end
      end
      vcsg_pkg::KIND_ODOM: begin
        odom_seen_nxt          = 1'b1;
        odom_ok_nxt            = sample_ok;
        odom_ref_nxt.odom_time = item.time_ms;
        if (sample_ok) begin
          odom_ref_nxt.good_seen = 1'b1;
          odom_ref_nxt.good_x    = item.axis_x;
          odom_ref_nxt.good_y    = item.axis_y;
          odom_ref_nxt.good_z    = item.axis_z;
        end
      end
      vcsg_pkg::KIND_CONF: begin
        loc_seen_nxt = 1'b1;
        loc_ok_nxt   = !item.not_finite && (item.confidence >= cfg.min_confidence);
        loc_time_nxt = item.time_ms;
      end
      vcsg_pkg::KIND_TICK: begin
        if (have_cmd_r) begin
          if (reason != vcsg_pkg::REASON_NONE) begin
            // Only the first failing tick after a move reports a stop.
            if (!stop_sent_r) begin
              res_valid     = 1'b1;
              stop_sent_nxt = 1'b1;
            end
          end else begin
            res_valid        = 1'b1;
            res.request_kind = vcsg_pkg::REQ_MOVE;
            res.vx           = vx_r;
            res.vy           = vy_r;
            res.vyaw         = vyaw_r;
            stop_sent_nxt    = 1'b0;
          end
        end
      end
      vcsg_pkg::KIND_SHUTDOWN: begin
        res_valid       = 1'b1;
        res.stop_reason = vcsg_pkg::REASON_SHUTDOWN;
        stop_sent_nxt   = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r        <= '0;
      vy_r        <= '0;
      vyaw_r      <= '0;
      cmd_time_r  <= '0;
      have_cmd_r  <= 1'b0;
      stop_sent_r <= 1'b1;
      odom_seen_r <= 1'b0;
      odom_ok_r   <= 1'b0;
      odom_ref_r  <= '0;
      loc_seen_r  <= 1'b0;
      loc_ok_r    <= 1'b0;
      loc_time_r  <= '0;
    end else if (take) begin
      vx_r        <= vx_nxt;
      vy_r        <= vy_nxt;
      vyaw_r      <= vyaw_nxt;
      cmd_time_r  <= cmd_time_nxt;
      have_cmd_r  <= have_cmd_nxt;
      stop_sent_r <= stop_sent_nxt;
      odom_seen_r <= odom_seen_nxt;
      odom_ok_r   <= odom_ok_nxt;
      odom_ref_r  <= odom_ref_nxt;
      loc_seen_r  <= loc_seen_nxt;
      loc_ok_r    <= loc_ok_nxt;
      loc_time_r  <= loc_time_nxt;
    end
  end

endmodule

/* tb/tb_velocity_command_safety_gate_top.sv */
// Self-checking testbench for velocity_command_safety_gate_top: a directed table, then
// randomized event streams under several register settings and idle patterns.
// Depends on vcsg_pkg and the top; each result is checked by a predictor or a fixed value.
module tb_velocity_command_safety_gate_top;
  import vcsg_pkg::*;

  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES   = 6;
  localparam int QUIET_LIMIT     = 3000;
  localparam int SHOWN_FAILS     = 10;
  localparam logic [2:0] KIND_UNUSED_FIRST = KIND_SHUTDOWN + 3'd1;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FIXED} check_e;

  typedef struct {
    item_t  w;
    check_e how;
    res_t   given;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  wire                in_stall;
  logic [2:0]         in_kind = '0;
  logic [31:0]        in_time_ms = '0;
  logic signed [23:0] in_axis_x = '0;
  logic signed [23:0] in_axis_y = '0;
  logic signed [23:0] in_axis_z = '0;
  logic [15:0]        in_confidence = '0;
  logic               in_not_finite = 1'b0;
  wire                out_valid;
  logic               out_stall = 1'b0;
  wire                out_request_kind;
  wire signed [15:0]  out_vx;
  wire signed [15:0]  out_vy;
  wire signed [15:0]  out_vyaw;
  wire [2:0]          out_stop_reason;
  logic               cfg_valid = 1'b0;
  wire                cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  // Travels with the input word so the monitor knows how to check it.
  check_e word_check = CHK_MODEL;
  res_t   word_given = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fails = 0;
  int quiet_cycles = 0;
  res_t requests_due[$];

  // Predictor state.
  cfg_t gate_cfg = '{max_vx: MAX_VX_RST, max_vy: MAX_VY_RST,
                     max_yaw_rate: MAX_YAW_RATE_RST,
                     cmd_timeout_ms: CMD_TIMEOUT_RST, odom_timeout_ms: ODOM_TIMEOUT_RST,
                     loc_timeout_ms: LOC_TIMEOUT_RST, min_confidence: MIN_CONF_RST,
                     loc_required: 1'b0};
  logic signed [15:0] held_vx = '0, held_vy = '0, held_vyaw = '0;
  logic [31:0]        cmd_stamp = '0, odom_stamp = '0, loc_stamp = '0;
  bit                 cmd_present = 0, stop_reported = 1;
  bit                 odom_present = 0, odom_valid = 0, anchor_present = 0;
  bit                 loc_present = 0, loc_valid = 0;
  logic signed [23:0] anchor_x = '0, anchor_y = '0, anchor_z = '0;

  velocity_command_safety_gate_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind), .in_time_ms(in_time_ms),
    .in_axis_x(in_axis_x), .in_axis_y(in_axis_y), .in_axis_z(in_axis_z),
    .in_confidence(in_confidence), .in_not_finite(in_not_finite),
    .out_valid(out_valid), .out_stall(out_stall), .out_request_kind(out_request_kind),
    .out_vx(out_vx), .out_vy(out_vy), .out_vyaw(out_vyaw), .out_stop_reason(out_stop_reason),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic res_t stop_of(input logic [2:0] why);
    res_t r;
    r = '0;
    r.request_kind = REQ_STOP;
    r.stop_reason = why;
    return r;
  endfunction

  function automatic res_t move_of(input logic signed [15:0] vx, input logic signed [15:0] vy,
                                   input logic signed [15:0] vyaw);
    res_t r;
    r = '0;
    r.request_kind = REQ_MOVE;
    r.vx = vx;
    r.vy = vy;
    r.vyaw = vyaw;
    r.stop_reason = REASON_NONE;
    return r;
  endfunction

  // Ages with the top bit set are treated as negative and never expire.
  function automatic bit aged_out(input logic [31:0] now_ms, input logic [31:0] then_ms,
                                  input logic [15:0] limit);
    logic [31:0] d;
    d = now_ms - then_ms;
    return (d < 32'h8000_0000) && (d > 32'(limit));
  endfunction

  function automatic logic signed [15:0] limit_speed(input logic signed [23:0] v,
                                                     input logic [14:0] lim);
    int vi;
    int li;
    vi = v;
    li = lim;
    if (vi > li) vi = li;
    else if (vi < -li) vi = -li;
    return 16'(vi);
  endfunction

  function automatic int keep_within(input int v, input int bound);
    if (v > bound) return bound;
    if (v < -bound) return -bound;
    return v;
  endfunction

  function automatic bit predict_request(input item_t w, output res_t r);
    longint px, py, pz, dx, dy, dz;
    logic [31:0] d;
    logic [2:0] why;
    bit ok;
    r = '0;
    case (w.kind)
      KIND_CMD: begin
        if (!w.not_finite) begin
          held_vx = limit_speed(w.axis_x, gate_cfg.max_vx);
          held_vy = limit_speed(w.axis_y, gate_cfg.max_vy);
          held_vyaw = limit_speed(w.axis_z, gate_cfg.max_yaw_rate);
          cmd_stamp = w.time_ms;
          cmd_present = 1;
        end
        return 0;
      end
      KIND_ODOM: begin
        px = longint'($signed(w.axis_x));
        py = longint'($signed(w.axis_y));
        pz = longint'($signed(w.axis_z));
        ok = !w.not_finite && (px < 0 ? -px : px) <= MAX_ABS_POSITION_MM_DEF &&
             (py < 0 ? -py : py) <= MAX_ABS_POSITION_MM_DEF &&
             (pz < 0 ? -pz : pz) <= MAX_ABS_Z_MM_DEF;
        if (ok && anchor_present) begin
          d = w.time_ms - odom_stamp;
          if (d != 0 && d < 32'(JUMP_WINDOW_MS_DEF)) begin
            dx = px - longint'(anchor_x);
            dy = py - longint'(anchor_y);
            dz = pz - longint'(anchor_z);
            if (dx * dx + dy * dy + dz * dz > longint'(MAX_JUMP_MM_DEF) * MAX_JUMP_MM_DEF)
              ok = 0;
          end
        end
        odom_present = 1;
        odom_valid = ok;
        odom_stamp = w.time_ms;
        if (ok) begin
          anchor_present = 1;
          anchor_x = w.axis_x;
          anchor_y = w.axis_y;
          anchor_z = w.axis_z;
        end
        return 0;
      end
      KIND_CONF: begin
        loc_present = 1;
        loc_valid = !w.not_finite && (w.confidence >= gate_cfg.min_confidence);
        loc_stamp = w.time_ms;
        return 0;
      end
      KIND_TICK: begin
        if (!cmd_present) return 0;
        why = REASON_NONE;
        if (!odom_present || !odom_valid ||
            aged_out(w.time_ms, odom_stamp, gate_cfg.odom_timeout_ms))
          why = REASON_ODOM;
        else if (gate_cfg.loc_required && (!loc_present || !loc_valid ||
                 aged_out(w.time_ms, loc_stamp, gate_cfg.loc_timeout_ms)))
          why = REASON_LOC;
        else if (aged_out(w.time_ms, cmd_stamp, gate_cfg.cmd_timeout_ms))
          why = REASON_CMD;
        if (why != REASON_NONE) begin
          // Only the first failing tick after a move reports the stop.
          if (stop_reported) return 0;
          stop_reported = 1;
          r = stop_of(why);
          return 1;
        end
        stop_reported = 0;
        r = move_of(held_vx, held_vy, held_vyaw);
        return 1;
      end
      KIND_SHUTDOWN: begin
        stop_reported = 1;
        r = stop_of(REASON_SHUTDOWN);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void log_fail(input string msg);
    fails++;
    if (fails <= SHOWN_FAILS) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    item_t w;
    res_t got;
    res_t want;
    bit made;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '0;
        got.request_kind = out_request_kind;
        got.vx = out_vx;
        got.vy = out_vy;
        got.vyaw = out_vyaw;
        got.stop_reason = out_stop_reason;
        if (requests_due.size() == 0) begin
          log_fail($sformatf("unexpected request: kind %0d vx %0d vy %0d vyaw %0d reason %0d",
                             got.request_kind, got.vx, got.vy, got.vyaw, got.stop_reason));
        end else begin
          want = requests_due.pop_front();
          if (got.request_kind !== want.request_kind || got.vx !== want.vx ||
              got.vy !== want.vy || got.vyaw !== want.vyaw ||
              got.stop_reason !== want.stop_reason)
            log_fail($sformatf({"request mismatch: expected kind %0d vx %0d vy %0d vyaw %0d",
                                " reason %0d, got kind %0d vx %0d vy %0d vyaw %0d reason %0d"},
                               want.request_kind, want.vx, want.vy, want.vyaw,
                               want.stop_reason, got.request_kind, got.vx, got.vy,
                               got.vyaw, got.stop_reason));
        end
      end
      if (in_valid && !in_stall) begin
        w.kind = in_kind;
        w.time_ms = in_time_ms;
        w.axis_x = in_axis_x;
        w.axis_y = in_axis_y;
        w.axis_z = in_axis_z;
        w.confidence = in_confidence;
        w.not_finite = in_not_finite;
        made = predict_request(w, want);
        if (word_check == CHK_FIXED) requests_due.push_back(word_given);
        else if (word_check == CHK_MODEL && made) requests_due.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_VX:       gate_cfg.max_vx = cfg_data[14:0];
          REG_MAX_VY:       gate_cfg.max_vy = cfg_data[14:0];
          REG_MAX_YAW_RATE: gate_cfg.max_yaw_rate = cfg_data[14:0];
          REG_CMD_TIMEOUT:  gate_cfg.cmd_timeout_ms = cfg_data;
          REG_ODOM_TIMEOUT: gate_cfg.odom_timeout_ms = cfg_data;
          REG_LOC_TIMEOUT:  gate_cfg.loc_timeout_ms = cfg_data;
          REG_MIN_CONF:     gate_cfg.min_confidence = cfg_data;
          REG_REQUIRE_LOC:  gate_cfg.loc_required = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_velocity_command_safety_gate_top NOT OK");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the word was taken.
  task automatic send_word(input item_t w, input check_e how, input res_t given);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= w.kind;
    in_time_ms <= w.time_ms;
    in_axis_x <= w.axis_x;
    in_axis_y <= w.axis_y;
    in_axis_z <= w.axis_z;
    in_confidence <= w.confidence;
    in_not_finite <= w.not_finite;
    word_check <= how;
    word_given <= given;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Ticks can leave the gate busy with no request due, so wait a few cycles more.
  task automatic settle();
    in_valid <= 1'b0;
    while (requests_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic row_t plan_row(input logic [2:0] kind, input logic [31:0] t,
                                    input int x, input int y, input int z,
                                    input logic [15:0] conf, input logic nf,
                                    input check_e how, input res_t given);
    row_t r;
    r.w.kind = kind;
    r.w.time_ms = t;
    r.w.axis_x = 24'(x);
    r.w.axis_y = 24'(y);
    r.w.axis_z = 24'(z);
    r.w.confidence = conf;
    r.w.not_finite = nf;
    r.how = how;
    r.given = given;
    return r;
  endfunction

  function automatic logic signed [23:0] speed_sample(input logic [14:0] lim);
    int reach;
    reach = int'(lim) + int'(lim) / 4 + 2;
    if ($urandom_range(9) == 0) return 24'($urandom);
    return 24'(int'($urandom_range(0, 2 * reach)) - reach);
  endfunction

  initial begin
    row_t rows[$];
    item_t w;
    int reg_val[8];
    int span, pick, walk_x, walk_y, walk_z, c;
    logic [31:0] clock_ms;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values throughout the table.
    rows.push_back(plan_row(KIND_TICK, 1000, 0, 0, 0, 0, 0, CHK_NONE, '0));
    rows.push_back(plan_row(KIND_SHUTDOWN, 1000, 0, 0, 0, 0, 0, CHK_FIXED,
                            stop_of(REASON_SHUTDOWN)));
    rows.push_back(plan_row(KIND_CMD, 1000, 8388607, -8388608, 123, 0, 0, CHK_NONE, '0));
    rows.push_back(plan_row(KIND_ODOM, 1001, 0, 0, 0, 0, 0, CHK_NONE, '0));
    rows.push_back(plan_row(KIND_TICK, 1002, 0, 0, 0, 0, 0, CHK_FIXED,
                            move_of(750, -350, 123)));
    rows.push_back(plan_row(KIND_TICK, 1502, 0, 0, 0, 0, 0, CHK_FIXED, stop_of(REASON_ODOM)));
    rows.push_back(plan_row(KIND_ODOM, 1600, 1500, 0, 0, 0, 0, CHK_MODEL, '0));
    rows.push_back(plan_row(KIND_CMD, 1600, -8388608, 8388607, -8388608, 0, 0, CHK_NONE, '0));
    rows.push_back(plan_row(KIND_CMD, 1600, 1, 1, 1, 16'hFFFF, 1, CHK_NONE, '0));
    rows.push_back(plan_row(KIND_TICK, 1601, 0, 0, 0, 0, 0, CHK_FIXED,
                            move_of(-750, 350, -1000)));
    rows.push_back(plan_row(KIND_ODOM, 1700, 3501, 0, 0, 0, 0, CHK_MODEL, '0));
    rows.push_back(plan_row(KIND_TICK, 1701, 0, 0, 0, 0, 0, CHK_FIXED, stop_of(REASON_ODOM)));
    rows.push_back(plan_row(KIND_ODOM, 1700, 100000, -100000, 5000, 0, 0, CHK_MODEL, '0));
    rows.push_back(plan_row(KIND_ODOM, 1800, 100001, 0, 0, 0, 0, CHK_MODEL, '0));
    rows.push_back(plan_row(KIND_ODOM, 1900, 0, 0, -5001, 0, 0, CHK_MODEL, '0));
    rows.push_back(plan_row(KIND_ODOM, 2900, -100000, 100000, -5000, 0, 0, CHK_MODEL, '0));
    rows.push_back(plan_row(KIND_CMD, 2900, 10, 20, 30, 0, 0, CHK_NONE, '0));
    rows.push_back(plan_row(KIND_TICK, 2901, 0, 0, 0, 0, 0, CHK_FIXED, move_of(10, 20, 30)));
    rows.push_back(plan_row(KIND_TICK, 3201, 0, 0, 0, 0, 0, CHK_FIXED, stop_of(REASON_CMD)));
    rows.push_back(plan_row(KIND_CONF, 3201, 0, 0, 0, 16'hFFFF, 0, CHK_NONE, '0));
    rows.push_back(plan_row(KIND_CONF, 3202, 0, 0, 0, 16'hFFFF, 1, CHK_NONE, '0));
    rows.push_back(plan_row(KIND_UNUSED_FIRST + 3'd2, 3202, -1, -1, -1, 16'hFFFF, 1,
                            CHK_NONE, '0));
    rows.push_back(plan_row(KIND_ODOM, 32'hFFFF_FFF0, 0, 0, 0, 0, 0, CHK_MODEL, '0));
    rows.push_back(plan_row(KIND_CMD, 32'hFFFF_FFF0, -1, -1, -1, 0, 0, CHK_NONE, '0));
    // Wrapped clock, then a tick that sits behind every stamp.
    rows.push_back(plan_row(KIND_TICK, 5, 0, 0, 0, 0, 0, CHK_FIXED, move_of(-1, -1, -1)));
    rows.push_back(plan_row(KIND_TICK, 32'hFFFF_FF00, 0, 0, 0, 0, 0, CHK_MODEL, '0));
    rows.push_back(plan_row(KIND_ODOM, 6, 0, 0, 0, 0, 1, CHK_MODEL, '0));
    rows.push_back(plan_row(KIND_TICK, 7, 0, 0, 0, 0, 0, CHK_FIXED, stop_of(REASON_ODOM)));

    foreach (rows[i]) send_word(rows[i].w, rows[i].how, rows[i].given);
    settle();

    clock_ms = 32'd10_000;
    walk_x = 0;
    walk_y = 0;
    walk_z = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      case (ph)
        0: reg_val = '{1, 1, 1, 1, 1, 1, 0, 1};
        1: reg_val = '{32767, 32767, 32767, 65535, 65535, 65535, 65535, 1};
        2: reg_val = '{MAX_VX_RST, MAX_VY_RST, MAX_YAW_RATE_RST, CMD_TIMEOUT_RST,
                       ODOM_TIMEOUT_RST, LOC_TIMEOUT_RST, MIN_CONF_RST, 0};
        3: reg_val = '{MAX_VX_RST, MAX_VY_RST, MAX_YAW_RATE_RST, CMD_TIMEOUT_RST,
                       ODOM_TIMEOUT_RST, LOC_TIMEOUT_RST, MIN_CONF_RST, 1};
        default: begin
          reg_val[REG_MAX_VX] = $urandom_range(1, $urandom_range(1) ? 32767 : 2000);
          reg_val[REG_MAX_VY] = $urandom_range(1, $urandom_range(1) ? 32767 : 2000);
          reg_val[REG_MAX_YAW_RATE] = $urandom_range(1, $urandom_range(1) ? 32767 : 2000);
          reg_val[REG_CMD_TIMEOUT] = $urandom_range(1, $urandom_range(1) ? 65535 : 1000);
          reg_val[REG_ODOM_TIMEOUT] = $urandom_range(1, $urandom_range(1) ? 65535 : 1000);
          reg_val[REG_LOC_TIMEOUT] = $urandom_range(1, $urandom_range(1) ? 65535 : 1000);
          reg_val[REG_MIN_CONF] = $urandom_range(0, 65535);
          reg_val[REG_REQUIRE_LOC] = $urandom_range(1);
        end
      endcase
      foreach (reg_val[i]) write_reg(3'(i), 16'(reg_val[i]));
      cfg_valid <= 1'b0;

      case (ph % 4)
        1: send_idle_pct = 82;
        2: recv_stall_pct = 82;
        3: begin
          send_idle_pct = 28;
          recv_stall_pct = 28;
        end
        default: ;
      endcase
      span = (reg_val[REG_CMD_TIMEOUT] < reg_val[REG_ODOM_TIMEOUT] ?
              reg_val[REG_CMD_TIMEOUT] : reg_val[REG_ODOM_TIMEOUT]) / 2 + 1;

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // Mostly small forward steps of the clock so that ticks find fresh state.
        pick = $urandom_range(99);
        if (pick < 2) clock_ms = $urandom;
        else if (pick < 5) clock_ms = clock_ms - $urandom_range(1, 1500);
        else if (pick < 15) clock_ms = clock_ms + $urandom_range(0, 2 * span + 2000);
        else clock_ms = clock_ms + $urandom_range(0, span);

        w = '0;
        w.time_ms = clock_ms;
        w.confidence = 16'($urandom);
        w.not_finite = ($urandom_range(99) < 4);
        pick = $urandom_range(99);
        if (pick < 24) begin
          w.kind = KIND_CMD;
          w.axis_x = speed_sample(gate_cfg.max_vx);
          w.axis_y = speed_sample(gate_cfg.max_vy);
          w.axis_z = speed_sample(gate_cfg.max_yaw_rate);
        end else if (pick < 50) begin
          w.kind = KIND_ODOM;
          pick = $urandom_range(99);
          if (pick < 70) begin
            walk_x = keep_within(walk_x + int'($urandom_range(0, 1200)) - 600,
                                 MAX_ABS_POSITION_MM_DEF);
            walk_y = keep_within(walk_y + int'($urandom_range(0, 1200)) - 600,
                                 MAX_ABS_POSITION_MM_DEF);
            walk_z = keep_within(walk_z + int'($urandom_range(0, 1200)) - 600,
                                 MAX_ABS_Z_MM_DEF);
          end else if (pick < 80) begin
            walk_x = int'($urandom_range(0, 2 * MAX_ABS_POSITION_MM_DEF))
                     - MAX_ABS_POSITION_MM_DEF;
            walk_y = int'($urandom_range(0, 2 * MAX_ABS_POSITION_MM_DEF))
                     - MAX_ABS_POSITION_MM_DEF;
            walk_z = int'($urandom_range(0, 2 * MAX_ABS_Z_MM_DEF)) - MAX_ABS_Z_MM_DEF;
          end else if (pick < 88) begin
            walk_x = $urandom_range(1) ? MAX_ABS_POSITION_MM_DEF : -MAX_ABS_POSITION_MM_DEF;
            walk_y = $urandom_range(1) ? MAX_ABS_POSITION_MM_DEF : -MAX_ABS_POSITION_MM_DEF;
            walk_z = $urandom_range(1) ? MAX_ABS_Z_MM_DEF : -MAX_ABS_Z_MM_DEF;
          end
          if (pick < 88) begin
            w.axis_x = 24'(walk_x);
            w.axis_y = 24'(walk_y);
            w.axis_z = 24'(walk_z);
          end else begin
            w.axis_x = 24'($urandom);
            w.axis_y = 24'($urandom);
            w.axis_z = 24'($urandom);
          end
        end else if (pick < 62) begin
          w.kind = KIND_CONF;
          if ($urandom_range(1)) begin
            c = int'(gate_cfg.min_confidence) + int'($urandom_range(0, 4)) - 2;
            w.confidence = 16'(c < 0 ? 0 : (c > 65535 ? 65535 : c));
          end
        end else if (pick < 94) begin
          w.kind = KIND_TICK;
        end else if (pick < 97) begin
          w.kind = KIND_SHUTDOWN;
        end else begin
          w.kind = KIND_UNUSED_FIRST + 3'($urandom_range(2));
        end
        send_word(w, CHK_MODEL, '0);
      end
      settle();
    end

    if (fails == 0 && requests_due.size() == 0) begin
      $display("tb_velocity_command_safety_gate_top OK");
    end else begin
      $display("tb_velocity_command_safety_gate_top NOT OK");
    end
    $finish;
  end

endmodule

/* velocity_command_safety_gate_top.f */
+incdir+src
src/vcsg_pkg.sv
src/vcsg_cfg_regs.sv
src/vcsg_odom_check.sv
src/vcsg_gate_core.sv
src/velocity_command_safety_gate_top.sv
tb/tb_velocity_command_safety_gate_top.sv
